@@ src/cdt_pkg.sv @@
// Shared definitions for the countdown timer with reload.
// Holds command codes, run-state codes, field widths and the status struct.
// No dependencies.
package cdt_pkg;

    localparam int unsigned CMD_W    = 4;
    localparam int unsigned STATE_W  = 2;
    localparam int unsigned FIELD_W  = 32;

    // Command codes carried in the input tuser.
    localparam logic [CMD_W-1:0] CMD_TICK          = 4'd0;
    localparam logic [CMD_W-1:0] CMD_START         = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ARM_PAUSED    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_STOP          = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PAUSE         = 4'd4;
    localparam logic [CMD_W-1:0] CMD_RESUME        = 4'd5;
    localparam logic [CMD_W-1:0] CMD_START_IN      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DELAY         = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SET_REMAINING = 4'd8;

    // Run-state codes.
    localparam logic [STATE_W-1:0] ST_STOPPED = 2'd0;
    localparam logic [STATE_W-1:0] ST_PAUSED  = 2'd1;
    localparam logic [STATE_W-1:0] ST_ACTIVE  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PERIOD      = 1'b0;
    localparam logic CFG_LOOP_ENABLE = 1'b1;

    // Status that the step logic hands back to the top level.
    typedef struct packed {
        logic                fired;
        logic [STATE_W-1:0]  run_state;
    } cdt_status_t;

endpackage

@@ src/cdt_step.sv @@
// Next-state logic of the countdown timer: one command applied to the count.
// Purely combinational; depends on cdt_pkg.
module cdt_step #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic [cdt_pkg::CMD_W-1:0]   cmd,
    input  logic [cdt_pkg::FIELD_W-1:0] elapsed,
    input  logic [cdt_pkg::FIELD_W-1:0] amount,
    input  logic                        subtract,
    input  logic                        fire_now,
    input  logic [cdt_pkg::FIELD_W-1:0] period,
    input  logic                        loop_enable,
    input  logic [COUNT_WIDTH-1:0]      remaining,
    input  logic [cdt_pkg::STATE_W-1:0] run_state,
    output logic [COUNT_WIDTH-1:0]      remaining_next,
    output cdt_pkg::cdt_status_t        status
);

    // Compare width covers both the count and the 32-bit fields.
    localparam int unsigned CW = (COUNT_WIDTH > cdt_pkg::FIELD_W) ? COUNT_WIDTH
                                                                  : cdt_pkg::FIELD_W;

    logic [CW-1:0]            rem_ext;
    logic [CW-1:0]            el_ext;
    logic [CW-1:0]            amt_ext;
    logic [CW-1:0]            period_ext;
    logic [COUNT_WIDTH-1:0]   period_w;
    logic [COUNT_WIDTH-1:0]   amt_w;
    logic                     expired;
    logic [CW-1:0]            el_diff;
    logic [CW-1:0]            amt_diff;
    logic [COUNT_WIDTH-1:0]   tick_rem;
    logic [cdt_pkg::STATE_W-1:0] tick_state;
    logic [COUNT_WIDTH-1:0]   add_a;
    logic [COUNT_WIDTH:0]     add_sum;
    logic [COUNT_WIDTH-1:0]   add_sat;

    assign rem_ext    = CW'(remaining);
    assign el_ext     = CW'(elapsed);
    assign amt_ext    = CW'(amount);
    assign period_ext = CW'(period);
    assign period_w   = period_ext[COUNT_WIDTH-1:0];
    assign amt_w      = amt_ext[COUNT_WIDTH-1:0];

    // Elapsed time applied to an active countdown.
    assign expired  = (el_ext >= rem_ext);
    assign el_diff  = rem_ext - el_ext;
    assign amt_diff = rem_ext - amt_ext;

    always_comb
    begin
        if (run_state != cdt_pkg::ST_ACTIVE)
        begin
            tick_rem   = remaining;
            tick_state = run_state;
        end
        else if (expired)
        begin
            tick_rem   = loop_enable ? period_w : '0;
            tick_state = loop_enable ? cdt_pkg::ST_ACTIVE : cdt_pkg::ST_STOPPED;
        end
        else
        begin
            tick_rem   = el_diff[COUNT_WIDTH-1:0];
            tick_state = run_state;
        end
    end

    // One saturating adder serves both start-in and lengthening delay.
    assign add_a   = (cmd == cdt_pkg::CMD_START_IN) ? period_w : remaining;
    assign add_sum = {1'b0, add_a} + {1'b0, amt_w};
    assign add_sat = add_sum[COUNT_WIDTH] ? '1 : add_sum[COUNT_WIDTH-1:0];

    always_comb
    begin
        remaining_next   = remaining;
        status.fired     = 1'b0;
        status.run_state = run_state;
        unique case (cmd)
            cdt_pkg::CMD_TICK:
            begin
                remaining_next   = tick_rem;
                status.run_state = tick_state;
                status.fired     = (run_state == cdt_pkg::ST_ACTIVE) && expired;
            end
            cdt_pkg::CMD_START:
            begin
                remaining_next   = fire_now ? '0 : period_w;
                status.run_state = cdt_pkg::ST_ACTIVE;
            end
            cdt_pkg::CMD_ARM_PAUSED:
            begin
                remaining_next   = fire_now ? '0 : period_w;
                status.run_state = cdt_pkg::ST_PAUSED;
            end
            cdt_pkg::CMD_STOP:
            begin
                remaining_next   = tick_rem;
                status.run_state = cdt_pkg::ST_STOPPED;
            end
            cdt_pkg::CMD_PAUSE:
            begin
                if (run_state == cdt_pkg::ST_ACTIVE)
                begin
                    remaining_next   = tick_rem;
                    status.run_state = cdt_pkg::ST_PAUSED;
                end
            end
            cdt_pkg::CMD_RESUME:
            begin
                if (run_state == cdt_pkg::ST_PAUSED)
                begin
                    status.run_state = cdt_pkg::ST_ACTIVE;
                end
            end
            cdt_pkg::CMD_START_IN:
            begin
                remaining_next   = add_sat;
                status.run_state = cdt_pkg::ST_ACTIVE;
            end
            cdt_pkg::CMD_DELAY:
            begin
                if (subtract)
                begin
                    remaining_next = (amt_ext >= rem_ext) ? '0 : amt_diff[COUNT_WIDTH-1:0];
                end
                else
                begin
                    remaining_next = add_sat;
                end
            end
            cdt_pkg::CMD_SET_REMAINING:
            begin
                remaining_next = amt_w;
            end
            default:
            begin
                remaining_next = remaining;
            end
        endcase
    end

endmodule

@@ src/countdown_timer_with_reload.sv @@
// Top level of the countdown timer with reload: stream ports, input register,
// timer state and result register. Depends on cdt_pkg and cdt_step.
//
// The timer takes one command word per clock while it is not stalled and
// returns exactly one result word per command, in order. A word accepted on
// the slave side is held in an input register while the step logic applies
// it to the countdown (one compare and one add or subtract on the count
// register). When it advances, it updates the timer state and loads the
// result register at the same edge. A result thus passes through the input
// register and the result register before it shows on the master side.
// Throughput is one word per cycle while the master side is ready, set by the update of the count register.
// The slave side keeps accepting while a finished result waits. It only
// stalls when both the input register and the result register are full and
// the master side is not ready. Elapsed time in a tick, stop or pause command
// is applied only while the timer is active. Stop and pause do not report a
// firing that their elapsed time causes. Start-in and lengthening delays
// saturate at the all-ones count, and shortening saturates at zero.
// Configuration writes (period, loop enable) take effect at once and belong
// in quiet times.
module countdown_timer_with_reload #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // elapsed[31:0], amount[63:32], subtract[64],
                                   // fire_now[65], zero fill[71:66]
    input  logic [3:0]  s_tuser,   // cmd[3:0]

    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // fired[0], timer_state[2:1], ticks_left[34:3],
                                   // zero fill[39:35]

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int unsigned CW = (COUNT_WIDTH > cdt_pkg::FIELD_W) ? COUNT_WIDTH
                                                                  : cdt_pkg::FIELD_W;

    // Configuration registers.
    logic [cdt_pkg::FIELD_W-1:0] period_reg;
    logic                        loop_enable_reg;

    // Input register.
    logic                        in_valid_reg;
    logic [cdt_pkg::CMD_W-1:0]   cmd_reg;
    logic [cdt_pkg::FIELD_W-1:0] elapsed_reg;
    logic [cdt_pkg::FIELD_W-1:0] amount_reg;
    logic                        subtract_reg;
    logic                        fire_now_reg;

    // Timer state.
    logic [COUNT_WIDTH-1:0]      remaining_reg;
    logic [COUNT_WIDTH-1:0]      remaining_next;
    logic [cdt_pkg::STATE_W-1:0] run_state_reg;

    // Result register.
    logic                        out_valid_reg;
    logic                        out_fired_reg;
    logic [cdt_pkg::STATE_W-1:0] out_state_reg;
    logic [cdt_pkg::FIELD_W-1:0] out_ticks_reg;

    cdt_pkg::cdt_status_t        step_status;
    logic                        advance;
    logic                        in_take;
    logic [CW-1:0]               rem_next_ext;

    // A word moves from the input register to the result register whenever
    // the result register is empty or being drained in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= '0;
            loop_enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cdt_pkg::CFG_PERIOD:      period_reg      <= cfg_wdata;
                cdt_pkg::CFG_LOOP_ENABLE: loop_enable_reg <= cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg      <= s_tuser;
            elapsed_reg  <= s_tdata[31:0];
            amount_reg   <= s_tdata[63:32];
            subtract_reg <= s_tdata[64];
            fire_now_reg <= s_tdata[65];
        end
    end

    cdt_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .cmd            (cmd_reg),
        .elapsed        (elapsed_reg),
        .amount         (amount_reg),
        .subtract       (subtract_reg),
        .fire_now       (fire_now_reg),
        .period         (period_reg),
        .loop_enable    (loop_enable_reg),
        .remaining      (remaining_reg),
        .run_state      (run_state_reg),
        .remaining_next (remaining_next),
        .status         (step_status)
    );

    assign rem_next_ext = CW'(remaining_next);

    // The timer state changes only when a command is applied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            run_state_reg <= cdt_pkg::ST_STOPPED;
        end
        else if (advance)
        begin
            remaining_reg <= remaining_next;
            run_state_reg <= step_status.run_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_fired_reg <= step_status.fired;
            out_state_reg <= step_status.run_state;
            out_ticks_reg <= rem_next_ext[cdt_pkg::FIELD_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_ticks_reg, out_state_reg, out_fired_reg};

    // A firing tick leaves the timer active (looping) or stopped, never paused.
    a_fired_not_paused: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fired_reg) |-> (out_state_reg != cdt_pkg::ST_PAUSED))
        else $error("fired result reports the paused state");

    // A firing that stopped the timer must have cleared the count.
    a_fired_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fired_reg && (out_state_reg == cdt_pkg::ST_STOPPED))
        |-> (out_ticks_reg == '0))
        else $error("fired and stopped result with a nonzero count");

    // The reported state is the state the timer was left in.
    a_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_state_reg == run_state_reg))
        else $error("result state differs from the timer state");

    // The slave side stalls only when both registers are full and blocked.
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

endmodule
